// File: rtl/windowed_sinc_resampler_core_macros.svh
// ---------------------------------------------------------------------------
// windowed sinc resampler assertion macros
// implication checks that compile away in synthesis
// ---------------------------------------------------------------------------
`ifndef WINDOWED_SINC_RESAMPLER_CORE_MACROS_SVH
`define WINDOWED_SINC_RESAMPLER_CORE_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define WSR_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
		else $error("resampler assertion failed");
// next-cycle implication
`define WSR_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error("resampler assertion failed");
`else
`define WSR_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define WSR_ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif
`endif

// File: rtl/wsr_pkg.sv
// ---------------------------------------------------------------------------
// wsr_pkg
// shared constants, types and codes of the windowed sinc resampler
// ---------------------------------------------------------------------------
package wsr_pkg;
	// phases per input sample, ring and table depths (depths powers of two)
	localparam int PHASES      = 120;
	localparam int RING_DEPTH  = 1024;
	localparam int TABLE_DEPTH = 8192;
	localparam int MAX_OUT     = 64;
	localparam int OWED_MAX    = 1023;

	localparam int RING_AW  = $clog2(RING_DEPTH);
	localparam int TAB_AW   = $clog2(TABLE_DEPTH);
	localparam int FRAC_W   = 16;
	localparam int PH_W     = $clog2(PHASES * 65536);
	localparam int PINT_W   = PH_W - FRAC_W;
	localparam int OWED_W   = 10;
	localparam int CNT_W    = 7;
	localparam int TAP_W    = 6;
	localparam int HT_W     = 5;
	localparam int INC_W    = 32;
	localparam int IDX_W    = 13;
	localparam int COEF_W   = 18;
	localparam int SAMP_W   = 24;
	localparam int ACC_W    = 49;

	// reciprocal of PHASES for the wrap count
	localparam int Q_W      = 17;
	localparam int RECIP_SH = 26;
	localparam int RECIP_W  = RECIP_SH;
	localparam int RECIP    = (1 << RECIP_SH) / PHASES + 1;
	localparam int WRAP_W   = Q_W;

	localparam logic [INC_W-1:0] INC_RESET = INC_W'(7864320);
	localparam logic [HT_W-1:0]  HT_RESET  = HT_W'(9);

	localparam logic REQ_TABLE  = 1'b0;
	localparam logic REQ_SAMPLE = 1'b1;

	typedef enum logic [0:0] {
		CFG_PHASE_INC = 1'b0,
		CFG_HALF_TAPS = 1'b1
	} cfg_idx_t;

	typedef logic signed [SAMP_W-1:0] sample_t;
	typedef logic signed [COEF_W-1:0] coef_t;

	typedef struct packed {
		logic valid;
		logic first;
		logic last;
	} tap_ctl_t;
endpackage

// File: rtl/wsr_ifs.sv
// ---------------------------------------------------------------------------
// resampler channel interfaces
// request, result and configuration channels with valid/ready
// ---------------------------------------------------------------------------
interface wsr_in_if;
	import wsr_pkg::*;
	logic                    valid;
	logic                    ready;
	logic                    req_type;
	logic [IDX_W-1:0]        coef_index;
	logic signed [COEF_W-1:0] coef_value;
	logic signed [SAMP_W-1:0] sample_in;
	modport source (output valid, req_type, coef_index, coef_value, sample_in, input ready);
	modport sink   (input valid, req_type, coef_index, coef_value, sample_in, output ready);
endinterface

interface wsr_out_if;
	import wsr_pkg::*;
	logic                     valid;
	logic                     ready;
	logic signed [SAMP_W-1:0] sample_out;
	logic                     last_of_run;
	modport source (output valid, sample_out, last_of_run, input ready);
	modport sink   (input valid, sample_out, last_of_run, output ready);
endinterface

interface wsr_cfg_if;
	import wsr_pkg::*;
	logic             valid;
	logic             ready;
	cfg_idx_t         index;
	logic [INC_W-1:0] data;
	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

// File: rtl/wsr_sample_ring.sv
// ---------------------------------------------------------------------------
// wsr_sample_ring
// audio ring memory with clearing sweep after reset
// ---------------------------------------------------------------------------
module wsr_sample_ring (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        wr_en,
	input  logic [wsr_pkg::RING_AW-1:0] wr_addr,
	input  wsr_pkg::sample_t            wr_data,
	input  logic [wsr_pkg::RING_AW-1:0] rd_addr,
	output wsr_pkg::sample_t            rd_data,
	output logic                        clearing
);
	import wsr_pkg::*;

	sample_t              mem [RING_DEPTH];
	logic [RING_AW-1:0]   clr_q;
	logic                 clearing_q;
	logic                 we;
	logic [RING_AW-1:0]   wa;
	sample_t              wd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q      <= '0;
			clearing_q <= 1'b1;
		end else if (clearing_q) begin
			clr_q <= clr_q + 1'b1;
			if (clr_q == RING_AW'(RING_DEPTH - 1)) clearing_q <= 1'b0;
		end
	end

	// sweep writes zeros, normal writes otherwise
	always_comb begin
		we = clearing_q | wr_en;
		wa = clearing_q ? clr_q : wr_addr;
		wd = clearing_q ? '0 : wr_data;
	end

	always_ff @(posedge clk) begin
		if (we) mem[wa] <= wd;
		rd_data <= mem[rd_addr];
	end

	assign clearing = clearing_q;
endmodule

// File: rtl/wsr_coef_table.sv
// ---------------------------------------------------------------------------
// wsr_coef_table
// window table memory, one write and two read ports
// ---------------------------------------------------------------------------
module wsr_coef_table (
	input  logic                       clk,
	input  logic                       wr_en,
	input  logic [wsr_pkg::TAB_AW-1:0] wr_addr,
	input  wsr_pkg::coef_t             wr_data,
	input  logic [wsr_pkg::TAB_AW-1:0] rd_addr0,
	input  logic [wsr_pkg::TAB_AW-1:0] rd_addr1,
	output wsr_pkg::coef_t             rd_data0,
	output wsr_pkg::coef_t             rd_data1
);
	import wsr_pkg::*;

	coef_t mem [TABLE_DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) mem[wr_addr] <= wr_data;
		rd_data0 <= mem[rd_addr0];
		rd_data1 <= mem[rd_addr1];
	end
endmodule

// File: rtl/wsr_mac.sv
// ---------------------------------------------------------------------------
// wsr_mac
// phase interpolation and multiply-accumulate pipeline, one tap a cycle
// ---------------------------------------------------------------------------
module wsr_mac (
	input  logic                       clk,
	input  logic                       arst_n,
	input  wsr_pkg::tap_ctl_t          ctl,
	input  logic [wsr_pkg::FRAC_W-1:0] frac,
	input  wsr_pkg::coef_t             w0,
	input  wsr_pkg::coef_t             w1,
	input  wsr_pkg::sample_t           samp,
	output logic                       done,
	output wsr_pkg::sample_t           result
);
	import wsr_pkg::*;

	localparam int DIFF_W = COEF_W + 1;
	localparam int DP_W   = DIFF_W + FRAC_W + 1;
	localparam int P_W    = DIFF_W + SAMP_W;

	tap_ctl_t                 ctl_s2, ctl_s3, ctl_s4;
	logic signed [DP_W-1:0]   dprod_s2;
	coef_t                    w0_s2;
	sample_t                  samp_s2, samp_s3;
	logic signed [DIFF_W-1:0] w_s3;
	logic signed [P_W-1:0]    p_s4;
	logic signed [ACC_W-1:0]  acc_q;
	logic                     done_q;
	logic signed [DIFF_W-1:0] diff;
	logic signed [DP_W-1:0]   dround;
	logic signed [ACC_W-1:0]  rnd;

	assign diff   = DIFF_W'(w1) - DIFF_W'(w0);
	assign dround = (dprod_s2 + DP_W'(32768)) >>> FRAC_W;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s2 <= '0;
			ctl_s3 <= '0;
			ctl_s4 <= '0;
			done_q <= 1'b0;
		end else begin
			ctl_s2 <= ctl;
			ctl_s3 <= ctl_s2;
			ctl_s4 <= ctl_s3;
			done_q <= ctl_s4.valid & ctl_s4.last;
		end
	end

	always_ff @(posedge clk) begin
		dprod_s2 <= DP_W'(diff) * $signed({1'b0, frac});
		w0_s2    <= w0;
		samp_s2  <= samp;
		w_s3     <= DIFF_W'(w0_s2) + dround[DIFF_W-1:0];
		samp_s3  <= samp_s2;
		p_s4     <= P_W'(w_s3) * P_W'(samp_s3);
		if (ctl_s4.valid) acc_q <= (ctl_s4.first ? '0 : acc_q) + ACC_W'(p_s4);
	end

	// round half up from q.17 and saturate
	always_comb begin
		rnd = (acc_q + ACC_W'(65536)) >>> 17;
		if (rnd > ACC_W'(8388607))       result = sample_t'(24'sh7FFFFF);
		else if (rnd < -ACC_W'(8388608)) result = sample_t'(24'sh800000);
		else                             result = rnd[SAMP_W-1:0];
	end

	assign done = done_q;
endmodule

// File: rtl/windowed_sinc_resampler_core.sv
// ---------------------------------------------------------------------------
// windowed_sinc_resampler_core
// bandlimited sample-rate converter: sample ring, window table, tap pipeline
// ---------------------------------------------------------------------------
//  channel  | dir | payload                                      | handshake
//  in_ch    | in  | req_type, coef_index, coef_value, sample_in  | valid/ready
//  out_ch   | out | sample_out, last_of_run                      | valid/ready
//  cfg_ch   | in  | index, data                                  | valid/ready
//
// for each output of an audio sample the single multiply-accumulate pipeline
// sums 2*half_taps+2 taps; up to 64 outputs per sample
// after reset the ring is swept to zero, in_ch not ready then
// a result waits in the output register while the next output is computed;
// the sequencer stalls only when it has a new result and out_ch still holds one
// ---------------------------------------------------------------------------
module windowed_sinc_resampler_core (
	input  logic  clk,
	input  logic  arst_n,
	wsr_in_if.sink    in_ch,
	wsr_out_if.source out_ch,
	wsr_cfg_if.sink   cfg_ch
);
	import wsr_pkg::*;
	`include "windowed_sinc_resampler_core_macros.svh"

	typedef enum logic [2:0] {
		S_IDLE,
		S_CHECK,
		S_TAPS,
		S_DRAIN,
		S_EMIT
	} state_t;

	state_t               state_q;
	logic [INC_W-1:0]     inc_q;
	logic [HT_W-1:0]      ht_q;
	logic [PH_W-1:0]      pf_q;
	logic [RING_AW-1:0]   wp_q;
	logic [OWED_W-1:0]    owed_q;
	logic [CNT_W-1:0]     n_q;
	logic [TAP_W-1:0]     t_q;
	logic [TAB_AW-1:0]    ta_q;
	logic [RING_AW-1:0]   ra_q;
	logic [FRAC_W-1:0]    f_q;
	sample_t              res_q;
	logic                 out_valid_q;
	sample_t              out_sample_q;
	logic                 out_last_q;
	tap_ctl_t             ctl_s1;

	// phase advance pipeline, runs freely off the committed phase
	logic [INC_W:0]       ph_s1;
	logic [Q_W+RECIP_W-1:0] prod_s2;
	logic [Q_W-1:0]       q_s2;
	logic [FRAC_W-1:0]    lo_s2;
	logic [PH_W-1:0]      pf_nx_s3;
	logic [OWED_W-1:0]    owed_nx_s3;
	logic [WRAP_W-1:0]    wraps;
	logic [Q_W-1:0]       rem;

	logic                 in_ready;
	logic                 in_acc;
	logic                 ring_clearing;
	sample_t              ring_rd;
	coef_t                tab_rd0, tab_rd1;
	logic                 mac_done;
	sample_t              mac_res;
	tap_ctl_t             ctl_now;
	logic                 tap_last;
	logic [TAB_AW-1:0]    a_start;
	logic [RING_AW-1:0]   r_start;
	logic                 tab_we;

	assign in_ready = (state_q == S_IDLE) && !ring_clearing;
	assign in_acc   = in_ch.valid && in_ready;
	assign in_ch.ready = in_ready;
	assign tab_we   = in_acc && (in_ch.req_type == REQ_TABLE)
		&& (int'(in_ch.coef_index) < TABLE_DEPTH);

	// config writes, always ready
	assign cfg_ch.ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inc_q <= INC_RESET;
			ht_q  <= HT_RESET;
		end else if (cfg_ch.valid) begin
			unique case (cfg_ch.index)
				CFG_PHASE_INC: inc_q <= cfg_ch.data;
				CFG_HALF_TAPS: ht_q  <= cfg_ch.data[HT_W-1:0];
			endcase
		end
	end

	// wrap count by reciprocal multiply, remainder becomes the new integer phase
	always_comb begin
		wraps = prod_s2[RECIP_SH +: WRAP_W];
		rem   = q_s2 - Q_W'(wraps * Q_W'(PHASES));
	end

	always_ff @(posedge clk) begin
		ph_s1      <= (INC_W + 1)'(pf_q) + (INC_W + 1)'(inc_q);
		q_s2       <= ph_s1[INC_W:FRAC_W];
		lo_s2      <= ph_s1[FRAC_W-1:0];
		prod_s2    <= (Q_W + RECIP_W)'(ph_s1[INC_W:FRAC_W]) * (Q_W + RECIP_W)'(RECIP);
		pf_nx_s3   <= {rem[PINT_W-1:0], lo_s2};
		owed_nx_s3 <= (wraps > WRAP_W'(OWED_MAX)) ? OWED_W'(OWED_MAX) : wraps[OWED_W-1:0];
	end

	// first tap addresses: centre minus half span minus integer phase
	always_comb begin
		a_start  = TAB_AW'(TABLE_DEPTH / 2 - int'(ht_q) * PHASES - int'(pf_q[PH_W-1:FRAC_W]));
		r_start  = wp_q - RING_AW'({ht_q, 1'b0}) - RING_AW'(2);
		tap_last = (t_q == {ht_q, 1'b1});
		ctl_now  = '{valid: (state_q == S_TAPS), first: (t_q == '0), last: tap_last};
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			pf_q        <= '0;
			wp_q        <= '0;
			owed_q      <= '0;
			n_q         <= '0;
			t_q         <= '0;
			ta_q        <= '0;
			ra_q        <= '0;
			f_q         <= '0;
			res_q       <= '0;
			out_valid_q <= 1'b0;
			out_sample_q <= '0;
			out_last_q  <= 1'b0;
		end else begin
			// in the emit state the output register is handled below
			if (out_valid_q && out_ch.ready && (state_q != S_EMIT)) out_valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (in_acc && (in_ch.req_type == REQ_SAMPLE)) begin
						wp_q    <= wp_q + 1'b1;
						owed_q  <= (owed_q != '0) ? owed_q - 1'b1 : '0;
						n_q     <= '0;
						state_q <= S_CHECK;
					end
				end
				S_CHECK: begin
					if ((owed_q == '0) && (n_q < CNT_W'(MAX_OUT))) begin
						t_q     <= '0;
						ta_q    <= a_start;
						ra_q    <= r_start;
						f_q     <= pf_q[FRAC_W-1:0];
						state_q <= S_TAPS;
					end else begin
						state_q <= S_IDLE;
					end
				end
				S_TAPS: begin
					t_q  <= t_q + 1'b1;
					ta_q <= ta_q + TAB_AW'(PHASES);
					ra_q <= ra_q + 1'b1;
					if (tap_last) state_q <= S_DRAIN;
				end
				S_DRAIN: begin
					if (mac_done) begin
						res_q   <= mac_res;
						state_q <= S_EMIT;
					end
				end
				S_EMIT: begin
					if (!out_valid_q || out_ch.ready) begin
						out_valid_q  <= 1'b1;
						out_sample_q <= res_q;
						out_last_q   <= (owed_nx_s3 != '0) || (n_q == CNT_W'(MAX_OUT - 1));
						pf_q         <= pf_nx_s3;
						owed_q       <= owed_nx_s3;
						n_q          <= n_q + 1'b1;
						state_q      <= S_CHECK;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// tap control is registered to line up with the registered memory read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) ctl_s1 <= '0;
		else         ctl_s1 <= ctl_now;
	end

	assign out_ch.valid       = out_valid_q;
	assign out_ch.sample_out  = out_sample_q;
	assign out_ch.last_of_run = out_last_q;

	wsr_sample_ring u_ring (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (in_acc && (in_ch.req_type == REQ_SAMPLE)),
		.wr_addr  (wp_q),
		.wr_data  (in_ch.sample_in),
		.rd_addr  (ra_q),
		.rd_data  (ring_rd),
		.clearing (ring_clearing)
	);

	wsr_coef_table u_table (
		.clk      (clk),
		.wr_en    (tab_we),
		.wr_addr  (in_ch.coef_index[TAB_AW-1:0]),
		.wr_data  (in_ch.coef_value),
		.rd_addr0 (ta_q),
		.rd_addr1 (ta_q + 1'b1),
		.rd_data0 (tab_rd0),
		.rd_data1 (tab_rd1)
	);

	wsr_mac u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl_s1),
		.frac   (f_q),
		.w0     (tab_rd0),
		.w1     (tab_rd1),
		.samp   (ring_rd),
		.done   (mac_done),
		.result (mac_res)
	);

	// a finished sum only turns up while the sequencer waits for it
	`WSR_ASSERT_IMP(a_done_in_drain, clk, arst_n, mac_done, state_q == S_DRAIN)
	// no requests taken during the ring sweep
	`WSR_ASSERT_IMP(a_no_in_clear, clk, arst_n, ring_clearing, !in_ch.ready)
	// results per sample never run past the limit
	`WSR_ASSERT_IMP(a_run_limit, clk, arst_n, state_q != S_IDLE, n_q <= CNT_W'(MAX_OUT))
	// a new result never overwrites one still waiting
	`WSR_ASSERT_NXT(a_emit_free, clk, arst_n,
		(state_q == S_EMIT) && out_valid_q && !out_ch.ready, state_q == S_EMIT)
endmodule
